// File: rtl/software_timer_bank_defines.svh
// Assertion macros shared by the timer bank checker.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef SOFTWARE_TIMER_BANK_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/stb_pkg.sv
// Package for the software timer bank: sizes, constants, codes and types.
// Depends on nothing; used by the top level and the checker.
package stb_pkg;

  localparam int TIMER_COUNT   = 8;
  localparam int IDX_W         = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CNT_W         = $clog2(TIMER_COUNT + 1);
  localparam int MS_W          = 10;
  localparam int SEC_W         = 32;
  localparam int MS_PER_SECOND = 1000;
  localparam int STEP_RESET    = 10;

  // Command codes of an input word.
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  // Scan sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // One timer entry held in the entry memory.
  typedef struct packed {
    logic             one_shot;
    logic [SEC_W-1:0] period;
    logic [SEC_W-1:0] last_fire;
  } entry_t;

endpackage

// File: rtl/software_timer_bank.sv
// Software timer bank top level: tick counting, entry memory and scan sequencer.
// Depends on stb_pkg.
//
//   The input channel (in_valid_i / in_stall_o) carries one word per command.
//   A load word writes one timer entry and arms or disarms it; it produces
//   nothing. A tick word adds tick_step_ms to the millisecond count; a tick
//   that reaches a second boundary clears it instead, counts a second and
//   starts a scan of the entry memory, one entry per cycle unless a fire
//   waits on a held output word, through a registered read; in_stall_o
//   stays high while the scan and any final flush run.
//   Each fire gives one output word (fired_index_o, current_second_o, last_o);
//   last_o marks the final word of the tick. A fire is held in a pending
//   register until the scan finds the next fire or ends.
//   The output word sits in a register; when out_stall_i is high it holds and
//   the scan pauses at the next fire that needs it, which lengthens the stall.
//   Reset clears the time counts and disarms every timer; tick_step_ms returns
//   to 10. Entry contents are not cleared and need a load before use. The user
//   must write tick_step_ms (cfg_we_i / cfg_data_i) only while idle; unenforced.
module software_timer_bank (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [2:0]  timer_index_i,
  input  logic [31:0] period_seconds_i,
  input  logic        one_shot_i,
  input  logic        enable_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  fired_index_o,
  output logic [31:0] current_second_o,
  output logic        last_o
);

  localparam int IdxW = stb_pkg::IDX_W;
  localparam int CntW = stb_pkg::CNT_W;
  localparam int MsW  = stb_pkg::MS_W;
  localparam int SecW = stb_pkg::SEC_W;

  // Registers.
  stb_pkg::state_e                  state_q, state_d;
  logic [MsW-1:0]                   step_q, step_d;
  logic [MsW-1:0]                   ms_q, ms_d;
  logic [SecW-1:0]                  sec_q, sec_d;
  logic [stb_pkg::TIMER_COUNT-1:0]  en_q, en_d;
  logic [CntW-1:0]                  rd_cnt_q, rd_cnt_d;
  logic                             ev_v_q, ev_v_d;
  logic [IdxW-1:0]                  ev_idx_q, ev_idx_d;
  logic                             pend_v_q, pend_v_d;
  logic [IdxW-1:0]                  pend_idx_q, pend_idx_d;
  logic                             out_v_q, out_v_d;
  logic [IdxW-1:0]                  out_idx_q, out_idx_d;
  logic [SecW-1:0]                  out_sec_q, out_sec_d;
  logic                             out_last_q, out_last_d;

  // Entry memory and its ports.
  stb_pkg::entry_t                  mem_q [stb_pkg::TIMER_COUNT];
  stb_pkg::entry_t                  rdata_q;
  logic                             mem_we;
  logic [IdxW-1:0]                  mem_waddr;
  stb_pkg::entry_t                  mem_wdata;
  logic                             mem_re;
  logic [IdxW-1:0]                  mem_raddr;

  // Internal control.
  logic            in_acc;
  logic            tick_acc;
  logic            load_acc;
  logic [MsW:0]    ms_sum;
  logic            boundary;
  logic            rd_done;
  logic            out_free;
  logic [SecW-1:0] elapsed;
  logic            fire;
  logic            ev_stall;
  logic            push_last;

  // Input handshake and tick arithmetic.
  assign in_acc   = in_valid_i && !in_stall_o;
  assign tick_acc = in_acc && (command_i == stb_pkg::CMD_TICK);
  assign load_acc = in_acc && (command_i == stb_pkg::CMD_LOAD);
  assign ms_sum   = {1'b0, ms_q} + {1'b0, step_q};
  assign boundary = ms_sum >= (MsW+1)'(stb_pkg::MS_PER_SECOND);

  // Scan evaluation of the entry held in the read register.
  assign rd_done  = rd_cnt_q == CntW'(stb_pkg::TIMER_COUNT);
  assign out_free = !out_v_q || !out_stall_i;
  assign elapsed  = sec_q - rdata_q.last_fire;
  assign fire     = ev_v_q && en_q[ev_idx_q] && (elapsed > rdata_q.period);
  assign ev_stall = fire && pend_v_q && !out_free;
  assign push_last = (state_q == stb_pkg::ST_FLUSH) && out_free;

  // Next state of the scan sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stb_pkg::ST_IDLE: begin
        if (tick_acc && boundary) state_d = stb_pkg::ST_SCAN;
      end
      stb_pkg::ST_SCAN: begin
        if (rd_done && !ev_v_q) state_d = pend_v_q ? stb_pkg::ST_FLUSH : stb_pkg::ST_IDLE;
      end
      stb_pkg::ST_FLUSH: begin
        if (out_free) state_d = stb_pkg::ST_IDLE;
      end
      default: state_d = stb_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: the input channel is held off while a scan or flush runs.
  always_comb begin
    unique case (state_q)
      stb_pkg::ST_IDLE: in_stall_o = 1'b0;
      default:          in_stall_o = 1'b1;
    endcase
  end

  // Datapath next values and memory port control.
  always_comb begin
    step_d     = step_q;
    ms_d       = ms_q;
    sec_d      = sec_q;
    en_d       = en_q;
    rd_cnt_d   = rd_cnt_q;
    ev_v_d     = ev_v_q;
    ev_idx_d   = ev_idx_q;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    out_v_d    = out_v_q;
    out_idx_d  = out_idx_q;
    out_sec_d  = out_sec_q;
    out_last_d = out_last_q;
    mem_we     = 1'b0;
    mem_waddr  = ev_idx_q;
    mem_wdata  = rdata_q;
    mem_re     = 1'b0;
    mem_raddr  = rd_cnt_q[IdxW-1:0];

    if (cfg_we_i) step_d = cfg_data_i;

    // The output word leaves when the receiver takes it.
    if (out_v_q && !out_stall_i) out_v_d = 1'b0;

    // Tick: advance the time counts and start a scan on a second boundary.
    if (tick_acc) begin
      if (boundary) begin
        ms_d     = '0;
        sec_d    = sec_q + 1'b1;
        rd_cnt_d = '0;
        pend_v_d = 1'b0;
      end else begin
        ms_d = ms_sum[MsW-1:0];
      end
    end

    // Load: write the entry and stamp it with the current second.
    if (load_acc && (32'(timer_index_i) < stb_pkg::TIMER_COUNT)) begin
      mem_we             = 1'b1;
      mem_waddr          = IdxW'(timer_index_i);
      mem_wdata.one_shot = one_shot_i;
      mem_wdata.period   = period_seconds_i;
      mem_wdata.last_fire = sec_q;
      en_d[IdxW'(timer_index_i)] = enable_i;
    end

    // Scan: read the next entry while the previous one is evaluated.
    if ((state_q == stb_pkg::ST_SCAN) && !ev_stall) begin
      if (!rd_done) begin
        mem_re   = 1'b1;
        ev_v_d   = 1'b1;
        ev_idx_d = rd_cnt_q[IdxW-1:0];
        rd_cnt_d = rd_cnt_q + 1'b1;
      end else begin
        ev_v_d = 1'b0;
      end
      if (fire) begin
        mem_we              = 1'b1;
        mem_waddr           = ev_idx_q;
        mem_wdata.last_fire = sec_q;
        if (rdata_q.one_shot) en_d[ev_idx_q] = 1'b0;
        // The older pending fire is now known not to be the last one.
        if (pend_v_q) begin
          out_v_d    = 1'b1;
          out_idx_d  = pend_idx_q;
          out_sec_d  = sec_q;
          out_last_d = 1'b0;
        end
        pend_v_d   = 1'b1;
        pend_idx_d = ev_idx_q;
      end
    end

    // End of scan: the pending fire goes out as the final word.
    if (push_last) begin
      out_v_d    = 1'b1;
      out_idx_d  = pend_idx_q;
      out_sec_d  = sec_q;
      out_last_d = 1'b1;
      pend_v_d   = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= stb_pkg::ST_IDLE;
      step_q   <= MsW'(stb_pkg::STEP_RESET);
      ms_q     <= '0;
      sec_q    <= '0;
      en_q     <= '0;
      rd_cnt_q <= '0;
      ev_v_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      ms_q     <= ms_d;
      sec_q    <= sec_d;
      en_q     <= en_d;
      rd_cnt_q <= rd_cnt_d;
      ev_v_q   <= ev_v_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ev_idx_q   <= ev_idx_d;
    pend_idx_q <= pend_idx_d;
    out_idx_q  <= out_idx_d;
    out_sec_q  <= out_sec_d;
    out_last_q <= out_last_d;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  assign out_valid_o      = out_v_q;
  assign fired_index_o    = 3'(out_idx_q);
  assign current_second_o = out_sec_q;
  assign last_o           = out_last_q;

endmodule

// File: rtl/stb_checker.sv
// Port-level checker for the software timer bank, bound to the top level.
// Depends on software_timer_bank_defines.svh and stb_pkg.
`include "software_timer_bank_defines.svh"

module stb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        command_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  fired_index_o,
  input logic [31:0] current_second_o,
  input logic        last_o
);

  logic        out_held;
  logic        load_acc;
  logic [35:0] out_word;

  assign out_held = out_valid_o && out_stall_i;
  assign load_acc = in_valid_i && !in_stall_o && (command_i == stb_pkg::CMD_LOAD);
  assign out_word = {fired_index_o, current_second_o, last_o};

  // A stalled output word keeps its value.
  `STB_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_word), "stalled word changed")

  // A load leaves the bank ready in the next cycle.
  `STB_ASSERT_NEXT(a_load_ready, load_acc, !in_stall_o, "bank busy after a load")

  // A word that is not the final one of a tick means the scan is still open.
  `STB_ASSERT_NOW(a_mid_busy, out_valid_o && !last_o, in_stall_o, "non-final word while idle")

endmodule

bind software_timer_bank stb_checker u_stb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .command_i       (command_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .fired_index_o   (fired_index_o),
  .current_second_o(current_second_o),
  .last_o          (last_o)
);
